/* sv/lrupe_pkg.sv */
`default_nettype none

package lrupe_pkg;

    // Fixed field widths of the stream payload
    localparam int ID_FIELD_W  = 8;
    localparam int CNT_FIELD_W = 4;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 24;

    // Command codes carried in the slave tuser
    localparam logic CMD_ACCESS = 1'b0;
    localparam logic CMD_EVICT  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } t_state;

    // Controller to datapath strobes
    typedef struct packed {
        logic load;   // capture the input transfer
        logic cmp;    // register per-entry compare flags
        logic upd;    // apply list update, load result register
    } t_dp_cmd;

endpackage

`default_nettype wire

/* sv/lrupe_ctrl.sv */
`default_nettype none

module lrupe_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output lrupe_pkg::t_dp_cmd  o_cmd
);

    lrupe_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic              can_write;

    assign can_write = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrupe_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            lrupe_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = lrupe_pkg::S_CMP;
                end
            end
            lrupe_pkg::S_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = lrupe_pkg::S_UPD;
            end
            lrupe_pkg::S_UPD: begin
                // wait here while the previous result is still held
                if (can_write) begin
                    o_cmd.upd   = 1'b1;
                    n_out_valid = 1'b1;
                    o_in_ready  = 1'b1;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = lrupe_pkg::S_CMP;
                    end else begin
                        n_state = lrupe_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = lrupe_pkg::S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

/* sv/lrupe_dp.sv */
`default_nettype none

module lrupe_dp #(
    parameter int CAPACITY = 8,
    parameter int ID_BITS  = 8
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  lrupe_pkg::t_dp_cmd                    i_cmd,
    input  wire                                   i_op,
    input  wire  [lrupe_pkg::ID_FIELD_W-1:0]      i_entry_id,
    input  wire                                   i_needs_fill,
    input  wire  [lrupe_pkg::ID_FIELD_W-1:0]      i_current_id,
    output logic                                  o_evicted_valid,
    output logic [lrupe_pkg::ID_FIELD_W-1:0]      o_evicted_id,
    output logic                                  o_dropped_valid,
    output logic [lrupe_pkg::ID_FIELD_W-1:0]      o_dropped_id,
    output logic                                  o_found,
    output logic [lrupe_pkg::CNT_FIELD_W-1:0]     o_fill_count
);

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int IXW = (ID_BITS > lrupe_pkg::ID_FIELD_W) ? ID_BITS : lrupe_pkg::ID_FIELD_W;
    localparam int CXW = (CW > lrupe_pkg::CNT_FIELD_W) ? CW : lrupe_pkg::CNT_FIELD_W;

    // latched transfer
    logic               r_op;
    logic               r_fill;
    logic [ID_BITS-1:0] r_id;
    logic [ID_BITS-1:0] r_cur;

    logic [IXW-1:0]     id_ext, cur_ext;

    // list, most recent first
    logic [ID_BITS-1:0] r_list [CAPACITY];
    logic [ID_BITS-1:0] n_list [CAPACITY];
    logic [CW-1:0]      r_cnt, n_cnt;

    // compare flags
    logic [CAPACITY-1:0] r_match, n_match;
    logic [CAPACITY-1:0] r_unp, n_unp;

    logic [CAPACITY:0]   hi;           // an unpinned entry at or below this position
    logic [CAPACITY-1:0] match_above;  // a match above this position
    logic [CAPACITY-1:0] ev_hot;
    logic [ID_BITS-1:0]  ev_sel [CAPACITY];
    logic [ID_BITS-1:0]  ev_id;
    logic [IXW-1:0]      ev_ext, dr_ext;
    logic [CXW-1:0]      cnt_ext;

    logic full, any_unp, any_match;
    logic is_evict, is_fill, is_access;

    logic                r_ev_valid, r_dr_valid, r_found;
    logic [lrupe_pkg::ID_FIELD_W-1:0] r_ev_id, r_dr_id;

    assign id_ext  = IXW'(i_entry_id);
    assign cur_ext = IXW'(i_current_id);

    assign full      = (r_cnt == CW'(CAPACITY));
    assign any_unp   = |r_unp;
    assign any_match = |r_match;
    assign is_evict  = (r_op == lrupe_pkg::CMD_EVICT);
    assign is_fill   = (r_op == lrupe_pkg::CMD_ACCESS) && r_fill;
    assign is_access = (r_op == lrupe_pkg::CMD_ACCESS) && !r_fill;

    assign hi[CAPACITY] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic               vld;
            logic               rm;
            logic               sh_fill;
            logic [ID_BITS-1:0] prev_v;
            logic [ID_BITS-1:0] next_v;
            logic [ID_BITS-1:0] upd_v;

            assign vld        = (CW'(g) < r_cnt);
            assign n_match[g] = vld && (r_list[g] == r_id);
            assign n_unp[g]   = vld && (r_list[g] != '0) && (r_list[g] != r_cur);

            assign hi[g]          = |(r_unp & ({CAPACITY{1'b1}} << g));
            assign match_above[g] = |(r_match & ~({CAPACITY{1'b1}} << g));
            assign ev_hot[g]      = r_unp[g] && !hi[g+1];
            assign rm             = !hi[g+1];
            assign ev_sel[g]      = ev_hot[g] ? r_list[g] : '0;

            if (g == 0) begin : g_head
                assign prev_v = r_id;
            end else begin : g_body
                assign prev_v = r_list[g-1];
            end
            if (g == CAPACITY - 1) begin : g_tail
                assign next_v = r_list[g];
            end else begin : g_mid
                assign next_v = r_list[g+1];
            end

            // fill shifts everything when not full or nothing goes, else only down to the gap
            assign sh_fill = !full || !any_unp || hi[g];

            always_comb begin
                upd_v = r_list[g];
                if (is_evict) begin
                    if (any_unp && rm) begin
                        upd_v = next_v;
                    end
                end else if (is_fill) begin
                    if (sh_fill) begin
                        upd_v = prev_v;
                    end
                end else begin
                    if (any_match && !match_above[g]) begin
                        upd_v = prev_v;
                    end
                end
            end

            assign n_list[g] = i_cmd.upd ? upd_v : r_list[g];

            always_ff @(posedge i_clk) begin
                r_list[g] <= n_list[g];
            end
        end
    endgenerate

    always_comb begin
        ev_id = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            ev_id = ev_id | ev_sel[i];
        end
    end

    assign ev_ext  = IXW'(ev_id);
    assign dr_ext  = IXW'(r_list[CAPACITY-1]);
    assign cnt_ext = CXW'(r_cnt);

    always_comb begin
        n_cnt = r_cnt;
        if (is_evict && any_unp) begin
            n_cnt = r_cnt - CW'(1);
        end else if (is_fill && !full) begin
            n_cnt = r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.upd) begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_fill <= i_needs_fill;
            r_id   <= id_ext[ID_BITS-1:0];
            r_cur  <= cur_ext[ID_BITS-1:0];
        end
        if (i_cmd.cmp) begin
            r_match <= n_match;
            r_unp   <= n_unp;
        end
        if (i_cmd.upd) begin
            r_ev_valid <= (is_evict || (is_fill && full)) && any_unp;
            r_ev_id    <= (is_evict || (is_fill && full)) ? ev_ext[lrupe_pkg::ID_FIELD_W-1:0]
                                                           : '0;
            r_dr_valid <= is_fill && full && !any_unp;
            r_dr_id    <= (is_fill && full && !any_unp) ? dr_ext[lrupe_pkg::ID_FIELD_W-1:0]
                                                         : '0;
            r_found    <= is_access && any_match;
        end
    end

    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_id    = r_ev_id;
    assign o_dropped_valid = r_dr_valid;
    assign o_dropped_id    = r_dr_id;
    assign o_found         = r_found;
    assign o_fill_count    = cnt_ext[lrupe_pkg::CNT_FIELD_W-1:0];

endmodule

`default_nettype wire

/* sv/lru_list_with_pinned_eviction.sv */
// Each item passes a compare stage, then a list update stage over the register list;
// a new item can be accepted as the update is applied, and the update waits while the
// previous result has not been taken.
// Reset: synchronous, active low; clears the entry count, controller state and the
// result valid. List contents are not cleared; only positions below the count are used.
`default_nettype none

module lru_list_with_pinned_eviction #(
    parameter int CAPACITY = 8,
    parameter int ID_BITS  = 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,

    // Request stream
    input  wire                                 i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [7:0] entry_id, [8] needs_fill, [16:9] current_id, [23:17] zero
    input  wire  [lrupe_pkg::S_TDATA_W-1:0]     i_s_axis_tdata,
    // [0] cmd (0 access, 1 evict)
    input  wire                                 i_s_axis_tuser,

    // Result stream
    output logic                                o_m_axis_tvalid,
    input  wire                                 i_m_axis_tready,
    // [0] evicted_valid, [8:1] evicted_id, [9] dropped_valid, [17:10] dropped_id,
    // [18] found, [22:19] fill_count, [23] zero
    output logic [lrupe_pkg::M_TDATA_W-1:0]     o_m_axis_tdata
);

    lrupe_pkg::t_dp_cmd                 dp_cmd;

    logic                               ev_valid;
    logic [lrupe_pkg::ID_FIELD_W-1:0]   ev_id;
    logic                               dr_valid;
    logic [lrupe_pkg::ID_FIELD_W-1:0]   dr_id;
    logic                               found;
    logic [lrupe_pkg::CNT_FIELD_W-1:0]  fill_count;

    // Controller: sequences capture, compare and update, owns the result valid.
    lrupe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (dp_cmd)
    );

    // Datapath: the recency list as a row of id registers with per-entry compare
    // and a neighbor-shift mux, plus the result register.
    lrupe_dp #(
        .CAPACITY (CAPACITY),
        .ID_BITS  (ID_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_op            (i_s_axis_tuser),
        .i_entry_id      (i_s_axis_tdata[7:0]),
        .i_needs_fill    (i_s_axis_tdata[8]),
        .i_current_id    (i_s_axis_tdata[16:9]),
        .o_evicted_valid (ev_valid),
        .o_evicted_id    (ev_id),
        .o_dropped_valid (dr_valid),
        .o_dropped_id    (dr_id),
        .o_found         (found),
        .o_fill_count    (fill_count)
    );

    // Result packing, most significant field first
    assign o_m_axis_tdata = {1'b0, fill_count, found, dr_id, dr_valid, ev_id, ev_valid};

endmodule

`default_nettype wire
